// ===== hw/rtl/sit_pkg.sv =====
// Shared types and constants for the segment crossing test.
// Depends on nothing; the top level imports it, while sit_div does not.
`default_nettype none

package sit_pkg;

    // Number formats: coordinates are signed Q8.8, slopes, intercepts and x are Q16.16.
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int CFRAC      = COORD_BITS / 2;
    localparam int QW         = 16 + FRAC_BITS;
    // Width of a coordinate after scaling to the Q16.16 grid.
    localparam int QC_W       = COORD_BITS + FRAC_BITS - CFRAC;

    // Slope divider: |dy| scaled by 2^FRAC_BITS over |dx|.
    localparam int S_NUM_W    = COORD_BITS + FRAC_BITS;
    localparam int S_DEN_W    = COORD_BITS;
    // Crossing divider: |n2 - n1| scaled by 2^FRAC_BITS over |m1 - m2|.
    localparam int X_DEN_W    = QW + 1;
    localparam int X_NUM_W    = X_DEN_W + FRAC_BITS;
    // Product of a scaled coordinate magnitude and a slope magnitude.
    localparam int P_W        = QC_W + QW;

    // Case codes reported with each result.
    localparam logic [1:0] CASE_BOTH_VERT = 2'd0;
    localparam logic [1:0] CASE_ONE_VERT  = 2'd1;
    localparam logic [1:0] CASE_GENERAL   = 2'd2;
    localparam logic [1:0] CASE_PARALLEL  = 2'd3;

    // One request: two segments as four endpoints, two's complement.
    typedef struct packed {
        logic [COORD_BITS-1:0] a_begin_x;
        logic [COORD_BITS-1:0] a_begin_y;
        logic [COORD_BITS-1:0] a_end_x;
        logic [COORD_BITS-1:0] a_end_y;
        logic [COORD_BITS-1:0] b_begin_x;
        logic [COORD_BITS-1:0] b_begin_y;
        logic [COORD_BITS-1:0] b_end_x;
        logic [COORD_BITS-1:0] b_end_y;
    } seg_t;

    // One result.
    typedef struct packed {
        logic       crosses;
        logic [1:0] case_code;
    } res_t;

    // Per-request context that rides along the pipeline.
    typedef struct packed {
        logic            avert;
        logic            bvert;
        logic [QC_W-1:0] qa0;
        logic [QC_W-1:0] qa1;
        logic [QC_W-1:0] qb0;
        logic [QC_W-1:0] qb1;
    } ctx_t;

    // Sideband of the segment A slope divider.
    typedef struct packed {
        logic            neg;
        logic [QC_W-1:0] yq;
        ctx_t            ctx;
    } lane_a_t;

    // Sideband of the segment B slope divider.
    typedef struct packed {
        logic            neg;
        logic [QC_W-1:0] yq;
    } lane_b_t;

    // Sideband of the crossing divider.
    typedef struct packed {
        logic neg;
        logic par;
        logic n_eq;
        ctx_t ctx;
    } lane_x_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sit_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Stand-alone; the top level of the segment crossing test instantiates it.
`default_nettype none

module sit_div #(
    parameter int NUM_W  = 32,
    parameter int DEN_W  = 16,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg  [NUM_W];
    logic [NUM_W-1:0]  quo_reg  [NUM_W];
    logic [NUM_W-1:0]  dvd_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg  [NUM_W];
    logic [SIDE_W-1:0] side_reg [NUM_W];

    genvar k;
    generate
        for (k = 0; k < NUM_W; k++)
        begin : g_stage
            logic              pv;
            logic [DEN_W-1:0]  prem;
            logic [DEN_W-1:0]  pden;
            logic [NUM_W-1:0]  pquo;
            logic [NUM_W-1:0]  pdvd;
            logic [SIDE_W-1:0] pside;
            logic [DEN_W:0]    trial;
            logic [DEN_W+1:0]  diff;

            // The first stage starts from the request, later ones from the stage before.
            if (k == 0)
            begin : g_first
                assign pv    = in_valid;
                assign prem  = '0;
                assign pden  = den;
                assign pquo  = '0;
                assign pdvd  = num;
                assign pside = side;
            end
            else
            begin : g_next
                assign pv    = v_reg[k-1];
                assign prem  = rem_reg[k-1];
                assign pden  = den_reg[k-1];
                assign pquo  = quo_reg[k-1];
                assign pdvd  = dvd_reg[k-1];
                assign pside = side_reg[k-1];
            end

            // Bring down the next dividend bit and try to subtract the divisor.
            assign trial = {prem, pdvd[NUM_W-1]};
            assign diff  = {1'b0, trial} - {2'b00, pden};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= pv;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
                    quo_reg[k]  <= {pquo[NUM_W-2:0], ~diff[DEN_W+1]};
                    dvd_reg[k]  <= {pdvd[NUM_W-2:0], 1'b0};
                    den_reg[k]  <= pden;
                    side_reg[k] <= pside;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/segment_intersection_test.sv =====
// Segment crossing test: one request per cycle sustained when the output is not
// stalled; a full, held output buffer stalls the whole pipeline.
// A request passes through the two bit-per-stage dividers (32 stages for the slopes,
// 49 for the crossing x), seven arithmetic stages and a two-entry output buffer.
// Reset clears all stage valid bits and empties the output buffer.
// Depends on sit_pkg and sit_div.
`default_nettype none

module segment_intersection_test (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_stall,
    input  sit_pkg::seg_t seg,
    output logic          res_valid,
    input  logic          res_stall,
    output sit_pkg::res_t res
);

    import sit_pkg::*;

    // Clamp a magnitude with a sign to the signed Q16.16 range.
    function automatic logic [QW-1:0] to_q(input logic neg, input logic [63:0] m);
        logic [63:0] lim;
        logic [63:0] c;
        lim = 64'd1 << (QW - 1);
        c   = (m > lim) ? lim : m;
        if (neg)
            to_q = -c[QW-1:0];
        else if (c == lim)
            to_q = c[QW-1:0] - 1'b1;
        else
            to_q = c[QW-1:0];
    endfunction

    // Saturate a value one bit wider than Q16.16.
    function automatic logic [QW-1:0] sat1(input logic [QW:0] v);
        if (v[QW] != v[QW-1])
            sat1 = v[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        else
            sat1 = v[QW-1:0];
    endfunction

    // Global advance: the pipeline moves unless the output buffer is full and held.
    logic       en;
    logic       pop;
    logic       push;
    logic [1:0] cnt_reg;
    res_t       buf0_reg;
    res_t       buf1_reg;
    logic       t7_valid_reg;
    res_t       t7_res_reg;

    assign pop       = (cnt_reg != 2'd0) && !res_stall;
    assign en        = (cnt_reg != 2'd2) || pop;
    assign seg_stall = !en;
    assign push      = en && t7_valid_reg;

    // Request decode: differences, magnitudes and scaled coordinates.
    logic [COORD_BITS:0]   dxa, dya, dxb, dyb;
    logic [COORD_BITS:0]   adxa, adya, adxb, adyb;
    ctx_t                  ctx_in;
    lane_a_t               lane_a_in;
    lane_b_t               lane_b_in;

    assign dxa  = {seg.a_begin_x[COORD_BITS-1], seg.a_begin_x}
                - {seg.a_end_x[COORD_BITS-1], seg.a_end_x};
    assign dya  = {seg.a_begin_y[COORD_BITS-1], seg.a_begin_y}
                - {seg.a_end_y[COORD_BITS-1], seg.a_end_y};
    assign dxb  = {seg.b_begin_x[COORD_BITS-1], seg.b_begin_x}
                - {seg.b_end_x[COORD_BITS-1], seg.b_end_x};
    assign dyb  = {seg.b_begin_y[COORD_BITS-1], seg.b_begin_y}
                - {seg.b_end_y[COORD_BITS-1], seg.b_end_y};
    assign adxa = dxa[COORD_BITS] ? -dxa : dxa;
    assign adya = dya[COORD_BITS] ? -dya : dya;
    assign adxb = dxb[COORD_BITS] ? -dxb : dxb;
    assign adyb = dyb[COORD_BITS] ? -dyb : dyb;

    assign ctx_in.avert = (seg.a_begin_x == seg.a_end_x);
    assign ctx_in.bvert = (seg.b_begin_x == seg.b_end_x);
    assign ctx_in.qa0   = {seg.a_begin_x, {(FRAC_BITS-CFRAC){1'b0}}};
    assign ctx_in.qa1   = {seg.a_end_x, {(FRAC_BITS-CFRAC){1'b0}}};
    assign ctx_in.qb0   = {seg.b_begin_x, {(FRAC_BITS-CFRAC){1'b0}}};
    assign ctx_in.qb1   = {seg.b_end_x, {(FRAC_BITS-CFRAC){1'b0}}};

    assign lane_a_in.neg = dya[COORD_BITS] ^ dxa[COORD_BITS];
    assign lane_a_in.yq  = {seg.a_begin_y, {(FRAC_BITS-CFRAC){1'b0}}};
    assign lane_a_in.ctx = ctx_in;
    assign lane_b_in.neg = dyb[COORD_BITS] ^ dxb[COORD_BITS];
    assign lane_b_in.yq  = {seg.b_begin_y, {(FRAC_BITS-CFRAC){1'b0}}};

    // Slope dividers for both segments.
    logic                div_a_valid;
    logic                div_b_valid;
    logic [S_NUM_W-1:0]  qa;
    logic [S_NUM_W-1:0]  qb;
    lane_a_t             lane_a;
    lane_b_t             lane_b;

    sit_div #(
        .NUM_W  (S_NUM_W),
        .DEN_W  (S_DEN_W),
        .SIDE_W ($bits(lane_a_t))
    ) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seg_valid),
        .num       ({adya[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .den       (adxa[COORD_BITS-1:0]),
        .side      (lane_a_in),
        .out_valid (div_a_valid),
        .quo       (qa),
        .out_side  (lane_a)
    );

    sit_div #(
        .NUM_W  (S_NUM_W),
        .DEN_W  (S_DEN_W),
        .SIDE_W ($bits(lane_b_t))
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (seg_valid),
        .num       ({adyb[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}),
        .den       (adxb[COORD_BITS-1:0]),
        .side      (lane_b_in),
        .out_valid (div_b_valid),
        .quo       (qb),
        .out_side  (lane_b)
    );

    // Stage T1: signed, saturated slopes.
    logic            t1_valid_reg;
    logic [QW-1:0]   t1_m1_reg, t1_m2_reg;
    logic [QC_W-1:0] t1_yqa_reg, t1_yqb_reg;
    ctx_t            t1_ctx_reg;

    // Stage T2: products of x0 and slope magnitudes.
    logic            t2_valid_reg;
    logic [P_W-1:0]  t2_pa_reg, t2_pb_reg;
    logic            t2_nega_reg, t2_negb_reg;
    logic [QW-1:0]   t2_m1_reg, t2_m2_reg;
    logic [QC_W-1:0] t2_yqa_reg, t2_yqb_reg;
    ctx_t            t2_ctx_reg;

    // Stage T3: scaled, saturated products.
    logic            t3_valid_reg;
    logic [QW-1:0]   t3_pa_reg, t3_pb_reg;
    logic [QW-1:0]   t3_m1_reg, t3_m2_reg;
    logic [QC_W-1:0] t3_yqa_reg, t3_yqb_reg;
    ctx_t            t3_ctx_reg;

    // Stage T4: intercepts, slope difference and parallel flag.
    logic            t4_valid_reg;
    logic [QW-1:0]   t4_n1_reg, t4_n2_reg;
    logic [QW:0]     t4_den_reg;
    logic            t4_par_reg;
    ctx_t            t4_ctx_reg;

    // Stage T5: operands of the crossing divider.
    logic               t5_valid_reg;
    logic [X_DEN_W-1:0] t5_num_reg;
    logic [X_DEN_W-1:0] t5_den_reg;
    lane_x_t            t5_lane_reg;

    logic [QC_W-1:0] ma_x0_next, mb_x0_next;
    logic [QW-1:0]   ma_m_next, mb_m_next;
    logic [QW:0]     na_next, nb_next;
    logic [QW:0]     num_x_next;
    lane_x_t         lane_x_next;

    assign ma_x0_next = t1_ctx_reg.qa0[QC_W-1] ? -t1_ctx_reg.qa0 : t1_ctx_reg.qa0;
    assign mb_x0_next = t1_ctx_reg.qb0[QC_W-1] ? -t1_ctx_reg.qb0 : t1_ctx_reg.qb0;
    assign ma_m_next  = t1_m1_reg[QW-1] ? -t1_m1_reg : t1_m1_reg;
    assign mb_m_next  = t1_m2_reg[QW-1] ? -t1_m2_reg : t1_m2_reg;

    assign na_next = {{(QW+1-QC_W){t3_yqa_reg[QC_W-1]}}, t3_yqa_reg}
                   - {t3_pa_reg[QW-1], t3_pa_reg};
    assign nb_next = {{(QW+1-QC_W){t3_yqb_reg[QC_W-1]}}, t3_yqb_reg}
                   - {t3_pb_reg[QW-1], t3_pb_reg};

    assign num_x_next       = {t4_n2_reg[QW-1], t4_n2_reg} - {t4_n1_reg[QW-1], t4_n1_reg};
    assign lane_x_next.neg  = num_x_next[QW] ^ t4_den_reg[QW];
    assign lane_x_next.par  = t4_par_reg;
    assign lane_x_next.n_eq = (t4_n1_reg == t4_n2_reg);
    assign lane_x_next.ctx  = t4_ctx_reg;

    // Valid bits of the arithmetic stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg <= div_a_valid && div_b_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= t4_valid_reg;
        end
    end

    // Data path of stages T1 through T5.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_m1_reg   <= to_q(lane_a.neg, 64'(qa));
            t1_m2_reg   <= to_q(lane_b.neg, 64'(qb));
            t1_yqa_reg  <= lane_a.yq;
            t1_yqb_reg  <= lane_b.yq;
            t1_ctx_reg  <= lane_a.ctx;

            t2_pa_reg   <= P_W'(ma_x0_next) * P_W'(ma_m_next);
            t2_pb_reg   <= P_W'(mb_x0_next) * P_W'(mb_m_next);
            t2_nega_reg <= t1_ctx_reg.qa0[QC_W-1] ^ t1_m1_reg[QW-1];
            t2_negb_reg <= t1_ctx_reg.qb0[QC_W-1] ^ t1_m2_reg[QW-1];
            t2_m1_reg   <= t1_m1_reg;
            t2_m2_reg   <= t1_m2_reg;
            t2_yqa_reg  <= t1_yqa_reg;
            t2_yqb_reg  <= t1_yqb_reg;
            t2_ctx_reg  <= t1_ctx_reg;

            t3_pa_reg   <= to_q(t2_nega_reg, 64'(t2_pa_reg[P_W-1:FRAC_BITS]));
            t3_pb_reg   <= to_q(t2_negb_reg, 64'(t2_pb_reg[P_W-1:FRAC_BITS]));
            t3_m1_reg   <= t2_m1_reg;
            t3_m2_reg   <= t2_m2_reg;
            t3_yqa_reg  <= t2_yqa_reg;
            t3_yqb_reg  <= t2_yqb_reg;
            t3_ctx_reg  <= t2_ctx_reg;

            t4_n1_reg   <= sat1(na_next);
            t4_n2_reg   <= sat1(nb_next);
            t4_den_reg  <= {t3_m1_reg[QW-1], t3_m1_reg} - {t3_m2_reg[QW-1], t3_m2_reg};
            t4_par_reg  <= (t3_m1_reg == t3_m2_reg);
            t4_ctx_reg  <= t3_ctx_reg;

            t5_num_reg  <= num_x_next[QW] ? -num_x_next : num_x_next;
            t5_den_reg  <= t4_den_reg[QW] ? -t4_den_reg : t4_den_reg;
            t5_lane_reg <= lane_x_next;
        end
    end

    // Crossing x divider.
    logic               div_x_valid;
    logic [X_NUM_W-1:0] qx;
    lane_x_t            lane_x;

    sit_div #(
        .NUM_W  (X_NUM_W),
        .DEN_W  (X_DEN_W),
        .SIDE_W ($bits(lane_x_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (t5_valid_reg),
        .num       ({t5_num_reg, {FRAC_BITS{1'b0}}}),
        .den       (t5_den_reg),
        .side      (t5_lane_reg),
        .out_valid (div_x_valid),
        .quo       (qx),
        .out_side  (lane_x)
    );

    // Stage T6: pick the crossing x and the case code.
    logic          t6_valid_reg;
    logic [QW-1:0] t6_x_reg;
    logic [1:0]    t6_code_reg;
    logic          t6_n_eq_reg;
    ctx_t          t6_ctx_reg;
    logic [QW-1:0] x_next;
    logic [1:0]    code_next;

    always_comb
    begin
        if (lane_x.ctx.avert)
            x_next = {{(QW-QC_W){lane_x.ctx.qa0[QC_W-1]}}, lane_x.ctx.qa0};
        else if (lane_x.ctx.bvert)
            x_next = {{(QW-QC_W){lane_x.ctx.qb0[QC_W-1]}}, lane_x.ctx.qb0};
        else
            x_next = to_q(lane_x.neg, 64'(qx));

        if (lane_x.ctx.avert && lane_x.ctx.bvert)
            code_next = CASE_BOTH_VERT;
        else if (lane_x.ctx.avert || lane_x.ctx.bvert)
            code_next = CASE_ONE_VERT;
        else if (lane_x.par)
            code_next = CASE_PARALLEL;
        else
            code_next = CASE_GENERAL;
    end

    // Stage T7: bounds test and final result.
    logic signed [QW-1:0] xs, a0s, a1s, b0s, b1s;
    logic                 in_a, in_b, hit;
    res_t                 res_next;

    assign xs  = $signed(t6_x_reg);
    assign a0s = QW'($signed(t6_ctx_reg.qa0));
    assign a1s = QW'($signed(t6_ctx_reg.qa1));
    assign b0s = QW'($signed(t6_ctx_reg.qb0));
    assign b1s = QW'($signed(t6_ctx_reg.qb1));
    assign in_a = ((a0s <= xs) && (xs <= a1s)) || ((a1s <= xs) && (xs <= a0s));
    assign in_b = ((b0s <= xs) && (xs <= b1s)) || ((b1s <= xs) && (xs <= b0s));
    assign hit  = (xs != a0s) && (xs != a1s) && in_a && in_b;

    always_comb
    begin
        res_next.case_code = t6_code_reg;
        case (t6_code_reg) inside
            CASE_BOTH_VERT:              res_next.crosses = 1'b0;
            CASE_PARALLEL:               res_next.crosses = t6_n_eq_reg;
            CASE_ONE_VERT, CASE_GENERAL: res_next.crosses = hit;
            default:                     res_next.crosses = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t6_valid_reg <= div_x_valid;
            t7_valid_reg <= t6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t6_x_reg    <= x_next;
            t6_code_reg <= code_next;
            t6_n_eq_reg <= lane_x.n_eq;
            t6_ctx_reg  <= lane_x.ctx;
            t7_res_reg  <= res_next;
        end
    end

    // Two-entry output buffer; the head entry drives the result port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (push && (cnt_reg == 2'd1))
            begin
                buf0_reg <= t7_res_reg;
            end
            else
            begin
                buf0_reg <= buf1_reg;
            end
            if (push && (cnt_reg == 2'd2))
            begin
                buf1_reg <= t7_res_reg;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                buf0_reg <= t7_res_reg;
            end
            else
            begin
                buf1_reg <= t7_res_reg;
            end
        end
    end

    assign res_valid = (cnt_reg != 2'd0);
    assign res       = buf0_reg;

endmodule

`default_nettype wire
